// ===== rtl/polygon_sat_overlap_macros.svh =====
// Assertion helpers shared by the polygon overlap RTL.
`ifndef POLYGON_SAT_OVERLAP_MACROS_SVH
`define POLYGON_SAT_OVERLAP_MACROS_SVH

// same-cycle implication
`define PSAT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSAT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/psat_pkg.sv =====
package psat_pkg;

   localparam int COORD_BITS    = 16;
   localparam int MAX_VERTS_DEF = 16;
   localparam int WIDE_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * WIDE_BITS;
   localparam int PROJ_BITS     = PROD_BITS + 1;
   localparam int DRAIN_CYCLES  = 2;
   localparam int DRAIN_W       = 2;

   localparam logic POLY_A = 1'b0;
   localparam logic POLY_B = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [WIDE_BITS-1:0]  wide_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [PROJ_BITS-1:0]  proj_type;

   typedef struct packed {
      logic      polygon_sel;
      coord_type vertex_x;
      coord_type vertex_y;
      coord_type origin_x;
      coord_type origin_y;
      logic      last_vertex;
   } req_type;

   typedef struct packed {
      logic overlap;
      logic too_many;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vert_type;

   // control that rides along with each multiply
   typedef struct packed {
      logic first;   // x product: starts a new dot product
      logic last;    // y product: dot product complete
      logic tag;     // polygon the projected vertex belongs to
      logic vfirst;  // first vertex of that polygon on this axis
   } mac_op_type;

endpackage

// ===== rtl/psat_vstore.sv =====
module psat_vstore #(
   parameter int MAX_VERTS = psat_pkg::MAX_VERTS_DEF,
   parameter int IDX_W     = $clog2(MAX_VERTS)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic               wr_sel,
   input  logic [IDX_W-1:0]   wr_addr,
   input  psat_pkg::vert_type wr_data,
   input  logic               rd_en,
   input  logic               rd_sel,
   input  logic [IDX_W-1:0]   rd_addr,
   output psat_pkg::vert_type rd_data
);
   import psat_pkg::*;

   vert_type mem_a_ff [MAX_VERTS];
   vert_type mem_b_ff [MAX_VERTS];
   vert_type rd_a_ff;
   vert_type rd_b_ff;
   logic     rd_sel_ff;

   always_ff @(posedge clock) begin
      if (wr_en && wr_sel == POLY_A) begin
         mem_a_ff[wr_addr] <= wr_data;
      end
      if (wr_en && wr_sel == POLY_B) begin
         mem_b_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff   <= mem_a_ff[rd_addr];
         rd_b_ff   <= mem_b_ff[rd_addr];
         rd_sel_ff <= rd_sel;
      end
   end

   assign rd_data = (rd_sel_ff == POLY_B) ? rd_b_ff : rd_a_ff;

endmodule

// ===== rtl/psat_proj.sv =====
module psat_proj (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 op_valid,
   input  psat_pkg::mac_op_type op,
   input  psat_pkg::wide_type   mul_a,
   input  psat_pkg::wide_type   mul_b,
   output logic                 gap
);
   import psat_pkg::*;

   prod_type   prod_ff;
   mac_op_type op_ff;
   logic       op_valid_ff;
   proj_type   acc_ff;
   logic       acc_valid_ff;
   logic       acc_tag_ff;
   logic       acc_vfirst_ff;
   proj_type   lo_a_ff;
   proj_type   hi_a_ff;
   proj_type   lo_b_ff;
   proj_type   hi_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         acc_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid;
         acc_valid_ff <= op_valid_ff && op_ff.last;
      end
   end

   // multiply, then accumulate x and y terms, then fold into the intervals
   always_ff @(posedge clock) begin
      prod_ff <= prod_type'(mul_a) * prod_type'(mul_b);
      op_ff   <= op;
      if (op_valid_ff) begin
         acc_ff        <= op_ff.first ? proj_type'(prod_ff) : acc_ff + proj_type'(prod_ff);
         acc_tag_ff    <= op_ff.tag;
         acc_vfirst_ff <= op_ff.vfirst;
      end
      if (acc_valid_ff && acc_tag_ff == POLY_A) begin
         if (acc_vfirst_ff || acc_ff < lo_a_ff) lo_a_ff <= acc_ff;
         if (acc_vfirst_ff || acc_ff > hi_a_ff) hi_a_ff <= acc_ff;
      end
      if (acc_valid_ff && acc_tag_ff == POLY_B) begin
         if (acc_vfirst_ff || acc_ff < lo_b_ff) lo_b_ff <= acc_ff;
         if (acc_vfirst_ff || acc_ff > hi_b_ff) hi_b_ff <= acc_ff;
      end
   end

   // touching intervals are not a gap
   assign gap = (hi_a_ff < lo_b_ff) || (hi_b_ff < lo_a_ff);

endmodule

// ===== rtl/polygon_sat_overlap.sv =====
// Separating-axis overlap test for two convex 2D polygons.
// Request channel (req_valid / req_stall / req_data): one vertex per request,
// all of polygon A, then all of polygon B; last_vertex marks each polygon's end.
// Vertex requests see no stall while idle. Only the last vertex of B starts a
// test; the block stalls requests until its result sits in the output register.
// A test takes the normal of each edge of A, then of B, as an axis and ends
// early when an axis separates. On each axis, every stored vertex of both
// polygons costs an x pass and a y pass through the one shared 17x17
// multiplier; each axis adds three vertex-memory reads, a drain and a check.
// Up to MAX_VERTS vertices are kept per polygon; more set too_many.
// Result channel (rsp_valid / rsp_stall / rsp_data): one result per pair,
// held in a register; while the receiver stalls, vertices of the next pair are
// still taken, and a following test waits for the register to free up.
// Reset clears counts, positions and the pending result; vertex memory is not
// cleared, and only entries below the counts are ever read.
`include "polygon_sat_overlap_macros.svh"

module polygon_sat_overlap #(
   parameter int MAX_VERTS = psat_pkg::MAX_VERTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psat_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psat_pkg::rsp_type rsp_data
);
   import psat_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTS);
   localparam int CNT_W = $clog2(MAX_VERTS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTS);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_START = 9'b000000010,
      S_EDGE0 = 9'b000000100,
      S_EDGE1 = 9'b000001000,
      S_EDGE2 = 9'b000010000,
      S_PROJ  = 9'b000100000,
      S_DRAIN = 9'b001000000,
      S_CHECK = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type          state_ff,      state_in;
   logic [CNT_W-1:0]   count_a_ff,    count_a_in;
   logic [CNT_W-1:0]   count_b_ff,    count_b_in;
   logic               ovf_ff,        ovf_in;
   vert_type           pos_a_ff,      pos_a_in;
   vert_type           pos_b_ff,      pos_b_in;
   logic               axis_poly_ff,  axis_poly_in;
   logic [IDX_W-1:0]   axis_idx_ff,   axis_idx_in;
   logic               proj_poly_ff,  proj_poly_in;
   logic [IDX_W-1:0]   proj_idx_ff,   proj_idx_in;
   logic               phase_ff,      phase_in;
   logic [DRAIN_W-1:0] drain_ff,      drain_in;
   vert_type           vi_ff,         vi_in;
   wide_type           ax_ff,         ax_in;
   wide_type           ay_ff,         ay_in;
   logic               hit_ff,        hit_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   rsp_type            rsp_ff,        rsp_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   vert_type           wr_data;
   logic               rd_en;
   logic               rd_sel;
   logic [IDX_W-1:0]   rd_addr;
   vert_type           rd_data;

   logic               op_valid;
   mac_op_type         op;
   wide_type           mul_a;
   wide_type           mul_b;
   logic               gap;

   logic [CNT_W-1:0]   axis_cnt;
   logic [CNT_W-1:0]   proj_cnt;
   logic               axis_last;
   logic               proj_last;
   vert_type           pos_sel;
   logic               rsp_take;

   psat_vstore #(
      .MAX_VERTS (MAX_VERTS),
      .IDX_W     (IDX_W)
   ) u_vstore (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_sel  (req_data.polygon_sel),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_sel  (rd_sel),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   psat_proj u_proj (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op       (op),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .gap      (gap)
   );

   assign axis_cnt  = (axis_poly_ff == POLY_B) ? count_b_ff : count_a_ff;
   assign proj_cnt  = (proj_poly_ff == POLY_B) ? count_b_ff : count_a_ff;
   assign axis_last = (CNT_W'(axis_idx_ff) + 1'b1) == axis_cnt;
   assign proj_last = (CNT_W'(proj_idx_ff) + 1'b1) == proj_cnt;
   assign pos_sel   = (proj_poly_ff == POLY_B) ? pos_b_ff : pos_a_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign wr_data   = '{x: req_data.vertex_x, y: req_data.vertex_y};

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ovf_in       = ovf_ff;
      pos_a_in     = pos_a_ff;
      pos_b_in     = pos_b_ff;
      axis_poly_in = axis_poly_ff;
      axis_idx_in  = axis_idx_ff;
      proj_poly_in = proj_poly_ff;
      proj_idx_in  = proj_idx_ff;
      phase_in     = phase_ff;
      drain_in     = drain_ff;
      vi_in        = vi_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      rd_en        = 1'b0;
      rd_sel       = POLY_A;
      rd_addr      = '0;
      op_valid     = 1'b0;
      op           = '0;
      mul_a        = ax_ff;
      mul_b        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.polygon_sel == POLY_A) begin
                  pos_a_in = '{x: req_data.origin_x, y: req_data.origin_y};
                  if (count_a_ff < MAX_CNT) begin
                     wr_en      = 1'b1;
                     wr_addr    = count_a_ff[IDX_W-1:0];
                     count_a_in = count_a_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  pos_b_in = '{x: req_data.origin_x, y: req_data.origin_y};
                  if (count_b_ff < MAX_CNT) begin
                     wr_en      = 1'b1;
                     wr_addr    = count_b_ff[IDX_W-1:0];
                     count_b_in = count_b_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_data.polygon_sel == POLY_B && req_data.last_vertex) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            if (count_a_ff == '0 || count_b_ff == '0) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               axis_poly_in = POLY_A;
               axis_idx_in  = '0;
               state_in     = S_EDGE0;
            end
         end
         S_EDGE0: begin
            rd_en    = 1'b1;
            rd_sel   = axis_poly_ff;
            rd_addr  = axis_idx_ff;
            state_in = S_EDGE1;
         end
         S_EDGE1: begin
            // edge end point wraps to vertex zero
            vi_in    = rd_data;
            rd_en    = 1'b1;
            rd_sel   = axis_poly_ff;
            rd_addr  = axis_last ? '0 : axis_idx_ff + 1'b1;
            state_in = S_EDGE2;
         end
         S_EDGE2: begin
            ax_in        = wide_type'(rd_data.y) - wide_type'(vi_ff.y);
            ay_in        = wide_type'(vi_ff.x) - wide_type'(rd_data.x);
            rd_en        = 1'b1;
            rd_sel       = POLY_A;
            rd_addr      = '0;
            proj_poly_in = POLY_A;
            proj_idx_in  = '0;
            phase_in     = 1'b0;
            state_in     = S_PROJ;
         end
         S_PROJ: begin
            op_valid  = 1'b1;
            op.tag    = proj_poly_ff;
            op.vfirst = (proj_idx_ff == '0);
            if (!phase_ff) begin
               op.first = 1'b1;
               mul_a    = ax_ff;
               mul_b    = wide_type'(pos_sel.x) + wide_type'(rd_data.x);
               phase_in = 1'b1;
            end else begin
               op.last  = 1'b1;
               mul_a    = ay_ff;
               mul_b    = wide_type'(pos_sel.y) + wide_type'(rd_data.y);
               phase_in = 1'b0;
               if (!proj_last) begin
                  rd_en       = 1'b1;
                  rd_sel      = proj_poly_ff;
                  rd_addr     = proj_idx_ff + 1'b1;
                  proj_idx_in = proj_idx_ff + 1'b1;
               end else if (proj_poly_ff == POLY_A) begin
                  rd_en        = 1'b1;
                  rd_sel       = POLY_B;
                  rd_addr      = '0;
                  proj_poly_in = POLY_B;
                  proj_idx_in  = '0;
               end else begin
                  drain_in = DRAIN_W'(DRAIN_CYCLES - 1);
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            // let the last product reach the interval registers
            if (drain_ff == '0) begin
               state_in = S_CHECK;
            end else begin
               drain_in = drain_ff - 1'b1;
            end
         end
         S_CHECK: begin
            if (gap) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else if (!axis_last) begin
               axis_idx_in = axis_idx_ff + 1'b1;
               state_in    = S_EDGE0;
            end else if (axis_poly_ff == POLY_A) begin
               axis_poly_in = POLY_B;
               axis_idx_in  = '0;
               state_in     = S_EDGE0;
            end else begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in    = 1'b1;
               rsp_in.overlap  = hit_ff;
               rsp_in.too_many = ovf_ff;
               count_a_in      = '0;
               count_b_in      = '0;
               ovf_in          = 1'b0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ovf_ff       <= 1'b0;
         pos_a_ff     <= '0;
         pos_b_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ovf_ff       <= ovf_in;
         pos_a_ff     <= pos_a_in;
         pos_b_ff     <= pos_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_poly_ff <= axis_poly_in;
      axis_idx_ff  <= axis_idx_in;
      proj_poly_ff <= proj_poly_in;
      proj_idx_ff  <= proj_idx_in;
      phase_ff     <= phase_in;
      drain_ff     <= drain_in;
      vi_ff        <= vi_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      hit_ff       <= hit_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PSAT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_a_ff <= MAX_CNT && count_b_ff <= MAX_CNT, "vertex count beyond store depth")
   `PSAT_ASSERT_IMP(a_proj_in_range, clock, reset, state_ff == S_PROJ,
      CNT_W'(proj_idx_ff) < proj_cnt, "projection reads past stored vertices")
   `PSAT_ASSERT_NXT(a_clear_after_result, clock, reset,
      state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall),
      count_a_ff == '0 && count_b_ff == '0 && !ovf_ff, "pair state not cleared after result")
   `PSAT_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_DONE, "result raised outside of completion")

endmodule
